// ----- sv/slp_pkg.sv -----
// ----------------------------------------------------------------------------
// slp_pkg: shared definitions of the store/load value predictor
// Table depth, derived widths and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package slp_pkg;

	localparam int ENTRIES = 64;
	localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W  = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 7;
	localparam int DATA_W  = 64;
	localparam int CMP_W   = (CAP_W > FILL_W) ? CAP_W : FILL_W;
	localparam int SUM_W   = FILL_W + 1;

	// Request operation codes.
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	// Lookup token that walks the chain, one cell per cycle.
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [DATA_W-1:0] pred;
	} token_t;

	// Request fields held stable while the token walks.
	typedef struct packed {
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              wr_ok;
	} req_t;

	// Insertion and eviction commands broadcast at the end of a walk.
	typedef struct packed {
		logic              ins_en;
		logic [SLOT_W-1:0] ins_slot;
		logic              inv_en;
		logic [SLOT_W-1:0] inv_slot;
	} ctl_t;

endpackage

// ----- sv/slp_cell.sv -----
// ----------------------------------------------------------------------------
// slp_cell: one table slot of the predictor chain
// Holds one address/value pair, compares it against the passing token and
// hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module slp_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [slp_pkg::SLOT_W-1:0] slot_id,
	input  slp_pkg::req_t             req,
	input  slp_pkg::ctl_t             ctl,
	input  slp_pkg::token_t           token_in,
	output slp_pkg::token_t           token_out
);
	import slp_pkg::*;

	logic [DATA_W-1:0] addr_q;
	logic [DATA_W-1:0] val_q;
	logic              valid_q;
	token_t            token_q;
	logic              match;
	logic              ins_here;

	assign match     = token_in.valid && valid_q && (addr_q == req.addr);
	assign ins_here  = ctl.ins_en && (ctl.ins_slot == slot_id);
	assign token_out = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			token_q <= '0;
		end else begin
			token_q.valid <= token_in.valid;
			token_q.hit   <= token_in.hit | match;
			token_q.pred  <= match ? val_q : token_in.pred;
			// Insertion wins over eviction when both name this slot.
			if (ins_here) begin
				valid_q <= 1'b1;
			end else if (ctl.inv_en && (ctl.inv_slot == slot_id)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_here) begin
			addr_q <= req.addr;
			val_q  <= req.data;
		end else if (match && req.wr_ok) begin
			// Overwriting with an equal value on a correct load is harmless.
			val_q <= req.data;
		end
	end

endmodule

// ----- sv/store_load_value_predictor_top.sv -----
// ----------------------------------------------------------------------------
// store_load_value_predictor_top: address-to-value predictor, FIFO replacement
// A request is taken when start is high and busy is low. Its lookup walks a
// chain of ENTRIES slot cells, one cell per cycle; when the token reaches the
// end of the chain, insertion and eviction are applied and busy falls, so a
// new request is not taken before the last one is through. The result is
// registered when the walk ends and is marked by done for exactly one
// cycle; the receiver cannot stall it, so it must take every result when
// done is high. The running counts stay on total_count and correct_count
// between results. The capacity register is written with cfg_we; the user
// must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module store_load_value_predictor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [63:0] address,
	input  logic [63:0] data_value,
	input  logic        read_ok,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	output logic        done,
	output logic [63:0] predicted_value,
	output logic        counted,
	output logic        correct,
	output logic [63:0] total_count,
	output logic [63:0] correct_count
);
	import slp_pkg::*;

	logic              busy_q;
	logic              go_q;
	logic              op_q;
	logic              read_ok_q;
	logic [CAP_W-1:0]  cap_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] hits_q;
	logic              done_q;
	logic [DATA_W-1:0] pred_q;
	logic              counted_q;
	logic              correct_q;
	req_t              req_q;
	ctl_t              ctl;
	token_t            chain [ENTRIES+1];
	token_t            tail;

	logic              accept;
	logic              fin;
	logic              is_load;
	logic [DATA_W-1:0] pred;
	logic              pred_ok;
	logic              insert;
	logic              evict;
	logic [CMP_W-1:0]  cap_ext;
	logic [FILL_W-1:0] eff_cap;
	logic [SLOT_W-1:0] oldest_n;
	logic [FILL_W-1:0] fill_mid;
	logic [SUM_W-1:0]  slot_sum;
	logic [SLOT_W-1:0] ins_slot;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign tail   = chain[ENTRIES];
	assign fin    = tail.valid;

	assign chain[0] = '{valid: go_q, hit: 1'b0, pred: '0};

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			slp_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.slot_id  (SLOT_W'(gi)),
				.req      (req_q),
				.ctl      (ctl),
				.token_in (chain[gi]),
				.token_out(chain[gi+1])
			);
		end
	endgenerate

	// End-of-walk decisions.
	always_comb begin
		is_load = (op_q == OP_LOAD) && read_ok_q;
		pred    = tail.hit ? tail.pred : '0;
		pred_ok = (pred == req_q.data);
		insert  = fin && !tail.hit && ((op_q == OP_STORE) || (is_load && !pred_ok));

		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			eff_cap = FILL_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = FILL_W'(ENTRIES);
		end else begin
			eff_cap = FILL_W'(cap_ext);
		end

		evict = insert && (fill_q >= eff_cap) && (fill_q != '0);
		if (evict) begin
			oldest_n = (oldest_q == SLOT_W'(ENTRIES - 1)) ? '0 : oldest_q + SLOT_W'(1);
			fill_mid = fill_q - FILL_W'(1);
		end else begin
			oldest_n = oldest_q;
			fill_mid = fill_q;
		end

		slot_sum = SUM_W'(oldest_n) + SUM_W'(fill_mid);
		if (slot_sum >= SUM_W'(ENTRIES)) begin
			slot_sum = slot_sum - SUM_W'(ENTRIES);
		end
		ins_slot = slot_sum[SLOT_W-1:0];

		ctl.ins_en   = insert;
		ctl.ins_slot = ins_slot;
		ctl.inv_en   = evict;
		ctl.inv_slot = oldest_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			go_q      <= 1'b0;
			cap_q     <= CAP_W'(64);
			fill_q    <= '0;
			oldest_q  <= '0;
			total_q   <= '0;
			hits_q    <= '0;
			done_q    <= 1'b0;
			counted_q <= 1'b0;
			correct_q <= 1'b0;
		end else begin
			go_q   <= accept;
			done_q <= fin;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (fin) begin
				counted_q <= is_load;
				correct_q <= is_load && pred_ok;
				if (is_load) begin
					total_q <= total_q + 64'd1;
					if (pred_ok) begin
						hits_q <= hits_q + 64'd1;
					end
				end
				oldest_q <= oldest_n;
				fill_q   <= insert ? fill_mid + FILL_W'(1) : fill_mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= op;
			read_ok_q    <= read_ok;
			req_q.addr   <= address;
			req_q.data   <= data_value;
			req_q.wr_ok  <= (op == OP_STORE) || read_ok;
		end
		if (fin) begin
			pred_q <= is_load ? pred : '0;
		end
	end

	assign done            = done_q;
	assign predicted_value = pred_q;
	assign counted         = counted_q;
	assign correct         = correct_q;
	assign total_count     = total_q;
	assign correct_count   = hits_q;

endmodule
